@@ src/rce_pkg.sv @@
// Package for the reference-counted epoch registry.
// Holds the command, status and cell operation codes and the stream widths.
// No dependencies.
`default_nettype none

package rce_pkg;

	localparam int ENTRIES_DEF = 32;
	localparam int KEY_W       = 64;
	localparam int REF_W       = 32;
	localparam int EPOCH_W     = 32;
	localparam int CMD_W       = 3;
	localparam int SLOT_W      = 6;
	localparam int STS_W       = 2;
	localparam int MASK_W      = 64;
	localparam int IN_W        = 80;
	localparam int OUT_W       = 72;

	localparam logic [CMD_W-1:0] CMD_LOOKUP   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSTALL  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_NEWEPOCH = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SHUTDOWN = 3'd4;

	localparam logic [STS_W-1:0] STS_OK      = 2'd0;
	localparam logic [STS_W-1:0] STS_MISS    = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL    = 2'd2;
	localparam logic [STS_W-1:0] STS_BADSLOT = 2'd3;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_TOUCH,
		OP_INSTALL,
		OP_RELEASE,
		OP_SWEEP,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		logic valid;
		logic hit;
		logic can_sweep;
	} cell_stat_t;

endpackage

`default_nettype wire

@@ src/refcounted_epoch_registry.sv @@
// Top level of the reference-counted epoch registry: request decode, slot
// selection, epoch register and result register around a row of cells.
// Depends on rce_pkg and rce_cell.
`default_nettype none

// The registry keeps ENTRIES slots, one cell each, that all compare a request's
// key at once. A request is first taken into a request register; then every
// cell reports hit, free and sweep flags, the lowest matching or free slot is
// picked and the chosen operation is written back into the cells while the
// result is loaded into the output register. The next request is taken once
// that result has been stored, so no new request is accepted while one is
// being evaluated; evaluation waits while an earlier result has not yet been
// taken. There is no clearing pass after reset.
module refcounted_epoch_registry #(
	parameter int ENTRIES = rce_pkg::ENTRIES_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	// [2:0] command, [66:3] key, [72:67] slot_in, [79:73] zero
	input  wire  [rce_pkg::IN_W-1:0]     s_tdata,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	// [1:0] status, [7:2] slot_out, [71:8] freed_mask
	output logic [rce_pkg::OUT_W-1:0]    m_tdata
);
	import rce_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EVAL = 2'b10
	} state_t;

	state_t              state_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [KEY_W-1:0]    key_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [EPOCH_W-1:0]  cur_epoch_q;
	logic [EPOCH_W-1:0]  new_epoch;

	logic [STS_W-1:0]    sts_q;
	logic [SLOT_W-1:0]   slot_out_q;
	logic [MASK_W-1:0]   mask_q;

	cell_stat_t          stat     [ENTRIES];
	logic [ENTRIES-1:0]  valid_vec;
	logic [ENTRIES-1:0]  hit_vec;
	logic [ENTRIES-1:0]  sweep_vec;
	logic [ENTRIES-1:0]  free_vec;
	logic [ENTRIES-1:0]  rel_vec;
	logic [ENTRIES-1:0]  hit_oh;
	logic [ENTRIES-1:0]  free_oh;
	logic [IDX_W-1:0]    hit_idx;
	logic [IDX_W-1:0]    free_idx;

	op_t                 op_c;
	op_t                 op_b;
	logic [ENTRIES-1:0]  sel_c;
	logic [STS_W-1:0]    sts_c;
	logic [SLOT_W-1:0]   slot_c;
	logic [MASK_W-1:0]   mask_c;
	logic                fire;
	logic                accept;

	assign new_epoch = (cur_epoch_q == '1) ? EPOCH_W'(1) : cur_epoch_q + EPOCH_W'(1);
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign fire      = (state_q == S_EVAL) && (!m_tvalid || m_tready);
	assign op_b      = fire ? op_c : OP_NONE;

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			rce_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.op        (op_b),
				.sel       (sel_c[g]),
				.key       (key_q),
				.cur_epoch (cur_epoch_q),
				.new_epoch (new_epoch),
				.stat      (stat[g])
			);
			assign valid_vec[g] = stat[g].valid;
			assign hit_vec[g]   = stat[g].hit;
			assign sweep_vec[g] = stat[g].can_sweep;
			assign rel_vec[g]   = stat[g].valid && (slot_q == SLOT_W'(g));
		end
	endgenerate

	assign free_vec = ~valid_vec;
	assign hit_oh   = hit_vec & (~hit_vec + ENTRIES'(1));
	assign free_oh  = free_vec & (~free_vec + ENTRIES'(1));

	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit_oh[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
			if (free_oh[i]) begin
				free_idx = free_idx | IDX_W'(i);
			end
		end
	end

	always_comb begin
		op_c   = OP_NONE;
		sel_c  = '0;
		sts_c  = STS_OK;
		slot_c = '0;
		mask_c = '0;
		case (cmd_q)
			CMD_LOOKUP: begin
				if (|hit_vec) begin
					op_c   = OP_TOUCH;
					sel_c  = hit_oh;
					slot_c = SLOT_W'(hit_idx);
				end else begin
					sts_c = STS_MISS;
				end
			end
			CMD_INSTALL: begin
				if (|hit_vec) begin
					op_c   = OP_TOUCH;
					sel_c  = hit_oh;
					slot_c = SLOT_W'(hit_idx);
				end else if (|free_vec) begin
					op_c   = OP_INSTALL;
					sel_c  = free_oh;
					slot_c = SLOT_W'(free_idx);
				end else begin
					sts_c = STS_FULL;
				end
			end
			CMD_RELEASE: begin
				if (|rel_vec) begin
					op_c  = OP_RELEASE;
					sel_c = rel_vec;
				end else begin
					sts_c = STS_BADSLOT;
				end
			end
			CMD_NEWEPOCH: begin
				op_c   = OP_SWEEP;
				mask_c = MASK_W'(sweep_vec);
			end
			CMD_SHUTDOWN: begin
				op_c   = OP_CLEAR;
				mask_c = MASK_W'(valid_vec);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_epoch_q <= EPOCH_W'(1);
			m_tvalid    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (fire) begin
				m_tvalid <= 1'b1;
				if (cmd_q == CMD_NEWEPOCH) begin
					cur_epoch_q <= new_epoch;
				end
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= s_tdata[2:0];
			key_q  <= s_tdata[66:3];
			slot_q <= s_tdata[72:67];
		end
		if (fire) begin
			sts_q      <= sts_c;
			slot_out_q <= slot_c;
			mask_q     <= mask_c;
		end
	end

	assign m_tdata = {mask_q, slot_out_q, sts_q};

endmodule

`default_nettype wire

@@ src/rce_cell.sv @@
// One registry cell: valid mark, key, reference count and epoch stamp of one slot.
// Compares its key and applies the operation broadcast by the top level.
// Depends on rce_pkg.
`default_nettype none

module rce_cell (
	input  wire                              clk,
	input  wire                              arst_n,
	input  rce_pkg::op_t                     op,
	input  wire                              sel,
	input  wire  [rce_pkg::KEY_W-1:0]        key,
	input  wire  [rce_pkg::EPOCH_W-1:0]      cur_epoch,
	input  wire  [rce_pkg::EPOCH_W-1:0]      new_epoch,
	output rce_pkg::cell_stat_t              stat
);
	import rce_pkg::*;

	logic               valid_q;
	logic [KEY_W-1:0]   key_q;
	logic [REF_W-1:0]   refs_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic               do_free;

	assign stat.valid     = valid_q;
	assign stat.hit       = valid_q && (key_q == key);
	assign stat.can_sweep = valid_q && (refs_q == '0) && (epoch_q != new_epoch);

	always_comb begin
		case (op)
			OP_SWEEP: do_free = stat.can_sweep;
			OP_CLEAR: do_free = valid_q;
			default:  do_free = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			refs_q  <= '0;
			epoch_q <= '0;
		end else if (do_free) begin
			valid_q <= 1'b0;
			refs_q  <= '0;
			epoch_q <= '0;
		end else if (sel) begin
			case (op)
				OP_TOUCH: begin
					if (refs_q != '1) begin
						refs_q <= refs_q + REF_W'(1);
					end
					epoch_q <= cur_epoch;
				end
				OP_INSTALL: begin
					valid_q <= 1'b1;
					refs_q  <= REF_W'(1);
					epoch_q <= cur_epoch;
				end
				OP_RELEASE: begin
					if (refs_q != '0) begin
						refs_q <= refs_q - REF_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sel && op == OP_INSTALL) begin
			key_q <= key;
		end
	end

endmodule

`default_nettype wire
